// ----- design/natural_log_series_estimate_top_macros.svh -----
// Assertion macros used by the checker of the natural log series block.
`ifndef NATURAL_LOG_SERIES_ESTIMATE_TOP_MACROS_SVH
`define NATURAL_LOG_SERIES_ESTIMATE_TOP_MACROS_SVH

// Same-cycle implication, off while reset is low.
`define NLSE_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while reset is low.
`define NLSE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also holds through reset.
`define NLSE_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/nlse_pkg.sv -----
`timescale 1ns / 1ps

package nlse_pkg;

    // Default and register layout
    localparam int unsigned DEF_MAX_TERMS   = 64;
    localparam int unsigned TC_W            = 7;
    localparam logic [TC_W-1:0] TERM_COUNT_RESET = 7'd8;

    // Stream widths
    localparam int unsigned X_W             = 32;
    localparam int unsigned OUT_W           = 32;
    localparam int unsigned OUT_DATA_W      = 3 * OUT_W;
    localparam logic [X_W-1:0] ONE_Q16      = 32'h0001_0000;

    // Shared restoring divider
    localparam int unsigned DIV_REM_W       = 33;
    localparam int unsigned DIV_Q_W         = 32;
    localparam int unsigned DIV_CNT_W       = 6;
    localparam logic [DIV_CNT_W-1:0] U_DIV_STEPS   = 6'd31;
    localparam logic [DIV_CNT_W-1:0] REL_DIV_STEPS = 6'd32;

    typedef struct packed {
        logic                 start;
        logic [DIV_CNT_W-1:0] steps;
    } t_div_req;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UDIV,
        S_UWAIT,
        S_SQ,
        S_SQW,
        S_TQ,
        S_TR,
        S_TC,
        S_TP,
        S_FIN,
        S_REL,
        S_RWAIT,
        S_DONE
    } t_state;

endpackage

// ----- design/nlse_div.sv -----
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle.
module nlse_div
    import nlse_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_div_req             i_req,
    input  logic [DIV_REM_W-1:0] i_rem_init,
    input  logic [DIV_Q_W-1:0]   i_low,
    input  logic [DIV_REM_W-1:0] i_divisor,
    output logic                 o_done,
    output logic [DIV_Q_W-1:0]   o_quot
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_REM_W-1:0] r_rem;
    logic [DIV_Q_W-1:0]   r_low;
    logic [DIV_REM_W-1:0] r_div;
    logic [DIV_Q_W-1:0]   r_quot;

    logic [DIV_REM_W:0]   w_shift;
    logic                 w_bit;
    logic [DIV_REM_W-1:0] n_rem;

    // Shift in the next dividend bit and try one subtract
    always_comb begin
        w_shift = {r_rem, r_low[DIV_Q_W-1]};
        w_bit   = (w_shift >= {1'b0, r_div});
        n_rem   = w_bit ? DIV_REM_W'(w_shift - {1'b0, r_div})
                        : w_shift[DIV_REM_W-1:0];
    end

    // Step count and done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Remainder, dividend bits and quotient
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem  <= i_rem_init;
            r_low  <= i_low;
            r_div  <= i_divisor;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= n_rem;
            r_low  <= {r_low[DIV_Q_W-2:0], 1'b0};
            r_quot <= {r_quot[DIV_Q_W-2:0], w_bit};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// ----- design/natural_log_series_estimate_top.sv -----
`timescale 1ns / 1ps

// Series estimate of ln(x) for x in unsigned Q16.16: u = (x-1)/(x+1) in Q1.30,
// ln = 2*sum of u^(2i-1)/(2i-1) over n terms, returned in signed Q8.24 along
// with the distance to the series cut after floor(n/2) terms and the relative
// error of that distance (saturating, flagged in tuser). n comes from the
// configuration register, 0 taken as 1 and clipped to MAX_TERMS. One item is
// worked at a time; the next is accepted only after the result has entered
// the output register, which waits while that register is full. The
// bit-serial divider spends 31 steps on u and 32 on the relative error (that
// division is skipped when the relative error saturates), and each term runs
// through S_TQ, S_TR, S_TC and S_TP, the first three of them passes of the single
// 31x32 multiplier (divide by 2i-1 through a reciprocal, back-multiply for the
// remainder check, next power). The input is ready only when idle; a finished
// result waits in the output register while the next item runs.
module natural_log_series_estimate_top
    import nlse_pkg::*;
#(
    parameter int unsigned MAX_TERMS = DEF_MAX_TERMS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [TC_W-1:0]       i_cfg_wdata,      // term_count
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [X_W-1:0]        i_s_axis_tdata,   // [31:0] x_value
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // [31:0] ln_estimate, [63:32] delta_estimate, [95:64] relative_error
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    output logic [0:0]            o_m_axis_tuser    // [0] relative_saturated
);

    localparam int unsigned CW    = $clog2(MAX_TERMS + 1);
    localparam int unsigned IW    = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int unsigned Q_W   = 31;
    localparam int unsigned FRAC_SHIFT = 30;
    localparam int unsigned MUL_W = 63;
    localparam int unsigned SUM_W = Q_W + CW;
    localparam int unsigned Q824_DROP = 5;

    // Reciprocals floor((2^32-1)/(2i+1)) for the term divisors
    logic [31:0] w_recip [MAX_TERMS];
    for (genvar g = 0; g < MAX_TERMS; g++) begin : g_recip
        localparam logic [31:0] RECIP = 32'hFFFF_FFFF / 32'(2 * g + 1);
        assign w_recip[g] = RECIP;
    end

    // Double a Q1.30 magnitude sum and clip it to a Q8.24 magnitude
    function automatic logic [OUT_W-1:0] clamp_mag(input logic [SUM_W-1:0] s,
                                                   input logic neg);
        logic [SUM_W:0] m;
        logic [SUM_W:0] lim;
        m   = {1'b0, s} >> Q824_DROP;
        lim = neg ? {{(SUM_W-31){1'b0}}, 32'h8000_0000}
                  : {{(SUM_W-31){1'b0}}, 32'h7FFF_FFFF};
        return (m > lim) ? lim[OUT_W-1:0] : m[OUT_W-1:0];
    endfunction

    t_state r_state, n_state;
    logic [TC_W-1:0]       r_term_count;
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic                  r_out_sat;

    logic [X_W-1:0]   r_x;
    logic [CW-1:0]    r_n;
    logic [CW-1:0]    r_half;
    logic [CW-1:0]    r_idx;
    logic             r_neg;
    logic [Q_W-1:0]   r_u;
    logic [Q_W-1:0]   r_u2;
    logic [Q_W-1:0]   r_p;
    logic [Q_W-1:0]   r_qe;
    logic [MUL_W-1:0] r_prod;
    logic [SUM_W-1:0] r_sum;
    logic [SUM_W-1:0] r_half_sum;
    logic [OUT_W-1:0] r_lnm;
    logic [OUT_W-1:0] r_hlm;
    logic [OUT_W-1:0] r_delta;
    logic [OUT_W-1:0] r_rel;
    logic             r_sat;

    logic                 w_accept;
    logic                 w_out_free;
    logic [CW-1:0]        w_n;
    logic                 w_x_neg;
    logic [X_W-1:0]       w_x_mag;
    logic [DIV_REM_W-1:0] w_den;
    logic [CW:0]          w_d;
    logic [CW-1:0]        w_idx_inc;
    logic                 w_last;
    logic [Q_W-1:0]       w_rem;
    logic [Q_W-1:0]       w_q;
    logic [SUM_W-1:0]     w_sum_next;
    logic [OUT_W-1:0]     w_delta;
    logic [OUT_W-1:0]     w_dmag;
    logic                 w_sat;
    logic [OUT_W-1:0]     w_ln;
    logic [Q_W-1:0]       w_mul_a;
    logic [31:0]          w_mul_b;
    t_div_req             w_div_req;
    logic [DIV_REM_W-1:0] w_div_rem;
    logic [DIV_Q_W-1:0]   w_div_low;
    logic [DIV_REM_W-1:0] w_div_divisor;
    logic                 w_div_done;
    logic [DIV_Q_W-1:0]   w_div_quot;

    nlse_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (w_div_req),
        .i_rem_init (w_div_rem),
        .i_low      (w_div_low),
        .i_divisor  (w_div_divisor),
        .o_done     (w_div_done),
        .o_quot     (w_div_quot)
    );

    // Datapath terms
    always_comb begin
        w_accept   = i_s_axis_tvalid && (r_state == S_IDLE);
        w_out_free = !r_out_valid || i_m_axis_tready;
        if (r_term_count == '0) begin
            w_n = CW'(1);
        end else if (32'(r_term_count) > 32'(MAX_TERMS)) begin
            w_n = CW'(MAX_TERMS);
        end else begin
            w_n = CW'(r_term_count);
        end
        w_x_neg    = (r_x < ONE_Q16);
        w_x_mag    = w_x_neg ? (ONE_Q16 - r_x) : (r_x - ONE_Q16);
        w_den      = {1'b0, r_x} + {1'b0, ONE_Q16};
        w_d        = {r_idx, 1'b1};
        w_idx_inc  = r_idx + CW'(1);
        w_last     = (w_idx_inc == r_n);
        w_rem      = r_p - r_prod[Q_W-1:0];
        w_q        = (w_rem >= Q_W'(w_d)) ? (r_qe + Q_W'(1)) : r_qe;
        w_sum_next = r_sum + SUM_W'(w_q);
        w_delta    = (r_lnm >= r_hlm) ? (r_lnm - r_hlm) : (r_hlm - r_lnm);
        w_dmag     = (r_lnm == '0) ? OUT_W'(1) : r_lnm;
        w_sat      = ({8'b0, w_delta} >= {w_dmag, 8'b0});
        w_ln       = r_neg ? (OUT_W'(0) - r_lnm) : r_lnm;
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_s_axis_tvalid) n_state = S_UDIV;
            S_UDIV:  n_state = S_UWAIT;
            S_UWAIT: if (w_div_done) n_state = S_SQ;
            S_SQ:    n_state = S_SQW;
            S_SQW:   n_state = S_TQ;
            S_TQ:    n_state = S_TR;
            S_TR:    n_state = S_TC;
            S_TC:    n_state = w_last ? S_FIN : S_TP;
            S_TP:    n_state = S_TQ;
            S_FIN:   n_state = S_REL;
            S_REL:   n_state = w_sat ? S_DONE : S_RWAIT;
            S_RWAIT: if (w_div_done) n_state = S_DONE;
            S_DONE:  if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Multiplier operands and divider requests
    always_comb begin
        w_mul_a         = r_p;
        w_mul_b         = '0;
        w_div_req.start = 1'b0;
        w_div_req.steps = U_DIV_STEPS;
        w_div_rem       = DIV_REM_W'(w_x_mag >> 1);
        w_div_low       = {w_x_mag[0], 31'b0};
        w_div_divisor   = w_den;
        unique case (r_state)
            S_UDIV: begin
                w_div_req.start = 1'b1;
            end
            S_SQ: begin
                w_mul_a = r_u;
                w_mul_b = 32'(r_u);
            end
            S_TQ: begin
                w_mul_b = w_recip[r_idx[IW-1:0]];
            end
            S_TR: begin
                w_mul_a = r_prod[MUL_W-1:32];
                w_mul_b = 32'(w_d);
            end
            S_TC: begin
                w_mul_b = 32'(r_u2);
            end
            S_REL: begin
                w_div_req.start = !w_sat;
                w_div_req.steps = REL_DIV_STEPS;
                w_div_rem       = DIV_REM_W'(w_delta >> 8);
                w_div_low       = {w_delta[7:0], 24'b0};
                w_div_divisor   = DIV_REM_W'(w_dmag);
            end
            default: begin
            end
        endcase
    end

    // State, configuration and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_term_count <= TERM_COUNT_RESET;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_term_count <= i_cfg_wdata;
            end
            if ((r_state == S_DONE) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Shared multiplier, one product per cycle
    always_ff @(posedge i_clk) begin
        r_prod <= MUL_W'(w_mul_a) * MUL_W'(w_mul_b);
    end

    // Working registers, advanced by the sequencer
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    r_x    <= i_s_axis_tdata;
                    r_n    <= w_n;
                    r_half <= w_n >> 1;
                end
            end
            S_UWAIT: begin
                if (w_div_done) begin
                    r_u <= w_div_quot[Q_W-1:0];
                end
            end
            S_SQW: begin
                r_u2       <= r_prod[FRAC_SHIFT+Q_W-1:FRAC_SHIFT];
                r_p        <= r_u;
                r_idx      <= '0;
                r_sum      <= '0;
                r_half_sum <= '0;
                r_neg      <= w_x_neg;
            end
            S_TR: begin
                r_qe <= r_prod[MUL_W-1:32];
            end
            S_TC: begin
                r_sum <= w_sum_next;
                if (w_idx_inc == r_half) begin
                    r_half_sum <= w_sum_next;
                end
            end
            S_TP: begin
                r_p   <= r_prod[FRAC_SHIFT+Q_W-1:FRAC_SHIFT];
                r_idx <= w_idx_inc;
            end
            S_FIN: begin
                r_lnm <= clamp_mag(r_sum, r_neg);
                r_hlm <= clamp_mag(r_half_sum, r_neg);
            end
            S_REL: begin
                r_delta <= w_delta;
                r_sat   <= w_sat;
                if (w_sat) begin
                    r_rel <= '1;
                end
            end
            S_RWAIT: begin
                if (w_div_done) begin
                    r_rel <= w_div_quot;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    r_out_data <= {r_rel, r_delta, w_ln};
                    r_out_sat  <= r_sat;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_s_axis_tready   = (r_state == S_IDLE);
    assign o_m_axis_tvalid   = r_out_valid;
    assign o_m_axis_tdata    = r_out_data;
    assign o_m_axis_tuser[0] = r_out_sat;

endmodule

// ----- design/nlse_checker.sv -----
`timescale 1ns / 1ps

`include "natural_log_series_estimate_top_macros.svh"

// Port-level checks on the natural log series block.
module nlse_checker
    import nlse_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_cfg_we,
    input logic [TC_W-1:0]       i_cfg_wdata,
    input logic                  i_s_axis_tvalid,
    input logic                  o_s_axis_tready,
    input logic [X_W-1:0]        i_s_axis_tdata,
    input logic                  o_m_axis_tvalid,
    input logic                  i_m_axis_tready,
    input logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    input logic [0:0]            o_m_axis_tuser
);

    // A beat in starts a run, so the input closes on the next cycle
    `NLSE_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_s_axis_tvalid && o_s_axis_tready, !o_s_axis_tready, "input still ready after a beat was taken")

    // A stalled result beat holds its payload
    `NLSE_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser), "stalled result beat changed")

    // Saturation flag means the relative error is at full scale
    `NLSE_ASSERT_SAME(a_sat_full_scale, i_clk, i_rst_n, o_m_axis_tvalid && o_m_axis_tuser[0], o_m_axis_tdata[95:64] == 32'hFFFF_FFFF, "saturated beat without full-scale error")

    // Zero distance gives zero relative error and no saturation
    `NLSE_ASSERT_SAME(a_zero_delta, i_clk, i_rst_n, o_m_axis_tvalid && (o_m_axis_tdata[63:32] == 32'd0), (o_m_axis_tdata[95:64] == 32'd0) && !o_m_axis_tuser[0], "nonzero relative error for zero delta")

    // Reset drops any pending result
    `NLSE_ASSERT_NEXT_ALWAYS(a_reset_clears, i_clk, !i_rst_n, !o_m_axis_tvalid, "result valid right after reset")

endmodule

bind natural_log_series_estimate_top nlse_checker u_nlse_checker (.*);

// ----- dv/natural_log_series_estimate_top_test.sv -----
`timescale 1ns / 1ps

module natural_log_series_estimate_top_test;
    import nlse_pkg::*;

    localparam int unsigned SERIES_LIMIT = DEF_MAX_TERMS;
    localparam int          TAIL_CYCLES  = 4 * SERIES_LIMIT + 100;
    localparam int          PRINT_CAP    = 60;

    typedef struct packed {
        logic [X_W-1:0] x_value;
        logic [31:0]    ln_q824;
        logic [31:0]    delta_q824;
        logic [31:0]    rel_q824;
        logic           rel_sat;
    } t_log_result;

    logic                  i_clk           = 1'b0;
    logic                  i_rst_n         = 1'b0;
    logic                  i_cfg_we        = 1'b0;
    logic [TC_W-1:0]       i_cfg_wdata     = '0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [X_W-1:0]        i_s_axis_tdata  = '0;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;
    logic [0:0]            o_m_axis_tuser;

    // Expected results in beat order, and the register as the block holds it
    t_log_result     ln_expect_q[$];
    logic [TC_W-1:0] term_count_shadow = TERM_COUNT_RESET;

    int  mismatch_count = 0;
    int  x_sent         = 0;
    int  results_seen   = 0;
    int  tc_writes      = 0;
    bit  tx_idle_on     = 1'b0;
    bit  rx_idle_on     = 1'b0;
    int  rx_hold_req    = 0;
    int  rx_hold_left   = 0;
    int  rx_stall_left  = 0;

    natural_log_series_estimate_top #(
        .MAX_TERMS(SERIES_LIMIT)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .o_m_axis_tuser (o_m_axis_tuser)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Signed Q1.30 product, magnitude truncated
    function automatic longint q30_mul(input longint a, input longint b);
        longint unsigned ma;
        longint unsigned mb;
        longint          m;
        ma = (a < 0) ? -a : a;
        mb = (b < 0) ? -b : b;
        m  = longint'((ma * mb) >> 30);
        return ((a < 0) != (b < 0)) ? -m : m;
    endfunction

    // Q1.30 sum to Q8.24, truncated toward zero and clipped to 32 bits
    function automatic longint sum_to_q824(input longint s);
        longint v;
        v = (s * 2) / 64;
        if (v > 64'sd2147483647)
            v = 64'sd2147483647;
        if (v < -64'sd2147483648)
            v = -64'sd2147483648;
        return v;
    endfunction

    // Full series estimate, half-length distance and relative error for one x
    function automatic t_log_result predict_ln_series(input logic [X_W-1:0] x,
                                                      input logic [TC_W-1:0] tc);
        t_log_result r;
        int          n;
        int          half;
        longint      num;
        longint      u;
        longint      u2;
        longint      p;
        longint      acc;
        longint      half_acc;
        longint      ln;
        longint      hl;
        longint      delta;
        longint      dmag;
        longint      rel;
        n = int'(tc);
        if (n < 1)
            n = 1;
        if (n > SERIES_LIMIT)
            n = SERIES_LIMIT;
        half = n / 2;
        num = longint'(x) - longint'(ONE_Q16);
        u   = (num * 64'sd1073741824) / (longint'(x) + longint'(ONE_Q16));
        u2  = q30_mul(u, u);
        p        = u;
        acc      = 0;
        half_acc = 0;
        for (int k = 1; k <= n; k++) begin
            acc += p / longint'(2 * k - 1);
            if (k == half)
                half_acc = acc;
            p = q30_mul(p, u2);
        end
        ln    = sum_to_q824(acc);
        hl    = sum_to_q824(half_acc);
        delta = (ln > hl) ? ln - hl : hl - ln;
        if (delta > 64'sd4294967295)
            delta = 64'sd4294967295;
        dmag = (ln < 0) ? -ln : ln;
        if (dmag < 1)
            dmag = 1;
        rel = (delta <<< 24) / dmag;
        r.rel_sat = 1'b0;
        if (rel > 64'sd4294967295) begin
            rel       = 64'sd4294967295;
            r.rel_sat = 1'b1;
        end
        r.x_value    = x;
        r.ln_q824    = ln[31:0];
        r.delta_q824 = delta[31:0];
        r.rel_q824   = rel[31:0];
        return r;
    endfunction

    // Mostly short idles, a few long ones
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(30, 80);
    endfunction

    // Spread x over the full range, near one, small and large magnitudes
    function automatic logic [X_W-1:0] pick_x();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            4: begin
                return ONE_Q16 + X_W'($urandom_range(0, 64)) - X_W'(32);
            end
            5: begin
                return X_W'($urandom_range(0, 16'hFFFF));
            end
            6: begin
                return 32'hFFFF_0000 | X_W'($urandom_range(0, 16'hFFFF));
            end
            7: begin
                return X_W'($urandom_range(0, 3)) | ($urandom_range(0, 1) ? 32'hFFFF_FFFC : '0);
            end
            default: begin
                return X_W'($urandom);
            end
        endcase
    endfunction

    task automatic report_mismatch(input string field, input logic [X_W-1:0] x,
                                   input logic [31:0] got, input logic [31:0] want_v);
        if (mismatch_count < PRINT_CAP)
            $display("[%0t] x=%08h %s: got %08h, want %08h", $time, x, field, got, want_v);
        mismatch_count++;
    endtask

    // Compare each output beat with the oldest expectation
    always @(posedge i_clk) begin : result_check
        t_log_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            results_seen++;
            if (ln_expect_q.size() == 0) begin
                report_mismatch("unexpected beat", '0, o_m_axis_tdata[31:0], '0);
            end else begin
                want = ln_expect_q.pop_front();
                if (o_m_axis_tdata[31:0] !== want.ln_q824)
                    report_mismatch("ln_estimate", want.x_value,
                                    o_m_axis_tdata[31:0], want.ln_q824);
                if (o_m_axis_tdata[63:32] !== want.delta_q824)
                    report_mismatch("delta_estimate", want.x_value,
                                    o_m_axis_tdata[63:32], want.delta_q824);
                if (o_m_axis_tdata[95:64] !== want.rel_q824)
                    report_mismatch("relative_error", want.x_value,
                                    o_m_axis_tdata[95:64], want.rel_q824);
                if (o_m_axis_tuser[0] !== want.rel_sat)
                    report_mismatch("relative_saturated", want.x_value,
                                    {31'd0, o_m_axis_tuser[0]}, {31'd0, want.rel_sat});
            end
        end
    end

    // Output ready: long hold-off on request, else random stalls
    always @(posedge i_clk) begin
        if (rx_hold_req != 0) begin
            rx_hold_left = rx_hold_req;
            rx_hold_req  = 0;
        end
        if (rx_hold_left != 0) begin
            rx_hold_left--;
            i_m_axis_tready <= 1'b0;
        end else if (rx_stall_left != 0) begin
            rx_stall_left--;
            i_m_axis_tready <= 1'b0;
        end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
            rx_stall_left = idle_length();
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    // Offer one x beat and hold it until accepted; valid stays high afterward
    task automatic send_x(input logic [X_W-1:0] x);
        int gap;
        gap = tx_idle_on ? idle_length() : 0;
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= x;
        do
            @(posedge i_clk);
        while (!o_s_axis_tready);
        ln_expect_q.push_back(predict_ln_series(x, term_count_shadow));
        x_sent++;
    endtask

    // Drop valid and wait until every expected result has come back
    task automatic wait_results_drained();
        i_s_axis_tvalid <= 1'b0;
        while (ln_expect_q.size() != 0)
            @(posedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic write_term_count(input logic [TC_W-1:0] value);
        wait_results_drained();
        i_cfg_wdata <= value;
        i_cfg_we    <= 1'b1;
        @(posedge i_clk);
        i_cfg_we          <= 1'b0;
        term_count_shadow  = value;
        tc_writes++;
    endtask

    // Argument corners at the reset term count
    task automatic test_argument_corners();
        logic [X_W-1:0] corner_x [10] = '{
            32'h0000_0001, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0001_0000, 32'h0000_FFFF,
            32'h0001_0001, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_8000, 32'h0002_0000
        };
        foreach (corner_x[k])
            send_x(corner_x[k]);
        wait_results_drained();
    endtask

    // Zero, single, minimal, maximal and over-range term counts
    task automatic test_term_count_corners();
        logic [TC_W-1:0] corner_tc [8] = '{7'd0, 7'd1, 7'd2, 7'd3, 7'd63, 7'd64, 7'd65, 7'd127};
        foreach (corner_tc[k]) begin
            write_term_count(corner_tc[k]);
            send_x((k % 2) ? 32'hFFFF_FFFF : 32'h0000_0000);
            send_x(X_W'($urandom));
        end
        wait_results_drained();
    endtask

    // Random x in phases, each with its own term count and idle pattern
    task automatic test_random_phases();
        logic [TC_W-1:0] tc;
        for (int phase = 0; phase < 8; phase++) begin
            if (phase == 0)
                tc = 7'd127;
            else if (phase == 1)
                tc = 7'd1;
            else if ($urandom_range(0, 2) == 0)
                tc = TC_W'($urandom_range(0, 127));
            else
                tc = TC_W'($urandom_range(1, 16));
            write_term_count(tc);
            tx_idle_on = (phase % 3) != 0;
            rx_idle_on = (phase % 3) != 1;
            repeat (45)
                send_x(pick_x());
            wait_results_drained();
        end
    endtask

    // Hold the output off long enough that the input backs up
    task automatic test_output_backpressure();
        write_term_count(7'd64);
        tx_idle_on  = 1'b0;
        rx_idle_on  = 1'b0;
        rx_hold_req = 1500;
        repeat (12)
            send_x(pick_x());
        wait_results_drained();
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_argument_corners();
        test_term_count_corners();
        test_output_backpressure();
        test_random_phases();

        wait_results_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Covered %0d x beats over %0d term count writes (0, 1, 64 and above 64 included).",
                 x_sent, tc_writes);
        $display("Checked %0d result beats, including a long output hold-off.", results_seen);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #8000000;
        $display("Timeout with %0d results outstanding", ln_expect_q.size());
        $display("Mismatches found");
        $finish;
    end

endmodule
